@@ sv/scbp_pkg.sv @@
// Shared types, constants and reset-value functions for the size class buffer pool.
package scbp_pkg;

  localparam int NUM_CLASSES  = 3;
  localparam int SMALL_COUNT  = 16;
  localparam int MEDIUM_COUNT = 16;
  localparam int BIG_COUNT    = 16;

  localparam int MAX_CLASSES  = 3;
  localparam int CLS_W        = 2;
  localparam int ID_W         = 6;
  localparam int ID_SLOTS     = 64;
  localparam int SIZE_W       = 16;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  localparam int ACTIVE_CLASSES = (NUM_CLASSES > MAX_CLASSES) ? MAX_CLASSES : NUM_CLASSES;

  localparam logic [ID_W-1:0] END_MARK = ID_W'(ID_SLOTS - 1);

  localparam logic [SIZE_W-1:0] SMALL_CAP_RST  = SIZE_W'(32);
  localparam logic [SIZE_W-1:0] MEDIUM_CAP_RST = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] BIG_CAP_RST    = SIZE_W'(128);

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [CLS_W-1:0] REG_SMALL_CAP  = CLS_W'(0);
  localparam logic [CLS_W-1:0] REG_MEDIUM_CAP = CLS_W'(1);
  localparam logic [CLS_W-1:0] REG_BIG_CAP    = CLS_W'(2);

  typedef enum logic [1:0] {
    STS_GRANTED  = 2'd0,
    STS_RELEASED = 2'd1,
    STS_NO_FIT   = 2'd2,
    STS_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } bk_state_t;

  typedef logic [MAX_CLASSES-1:0][SIZE_W-1:0] caps_t;

  typedef struct packed {
    logic              act;
    logic              ok;
    logic [CLS_W-1:0]  cls;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } op_t;

  function automatic int class_count(input int c);
    int n;
    n = 0;
    case (c)
      0:       n = SMALL_COUNT;
      1:       n = MEDIUM_COUNT;
      2:       n = BIG_COUNT;
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic int calc_id_limit();
    int total;
    total = 0;
    for (int c = 0; c < ACTIVE_CLASSES; c++) begin
      total += class_count(c);
    end
    return (total > ID_SLOTS - 1) ? ID_SLOTS - 1 : total;
  endfunction

  localparam int ID_LIMIT = calc_id_limit();

  function automatic logic [ID_W-1:0] class_first(input int c);
    int start;
    logic [ID_W-1:0] r;
    start = 0;
    r = END_MARK;
    for (int k = 0; k < MAX_CLASSES; k++) begin
      if (k == c && k < ACTIVE_CLASSES && start < ID_LIMIT) begin
        r = ID_W'(start);
      end
      start += class_count(k);
    end
    return r;
  endfunction

  function automatic logic [ID_W-1:0] link_reset(input logic [ID_W-1:0] id);
    int start;
    int nxt;
    logic [ID_W-1:0] r;
    start = 0;
    nxt = int'(id) + 1;
    r = END_MARK;
    for (int k = 0; k < ACTIVE_CLASSES; k++) begin
      if (int'(id) >= start && nxt < start + class_count(k) && nxt < ID_LIMIT) begin
        r = ID_W'(nxt);
      end
      start += class_count(k);
    end
    return r;
  endfunction

endpackage

@@ sv/size_class_buffer_pool.sv @@
// Top level of the size class buffer pool: APB register file, front end, queue, back end.
//
//  channel  dir  handshake           payload
//  in_      in   in_valid/in_ready   in_action, in_req_size, in_buffer_id, in_buffer_size
//  out_     out  out_valid/out_ready out_status, out_granted_id, out_granted_size
//  cfg      in   psel/penable/pready paddr, pwrite, pwdata, prdata
//
// The back end handles each request in two states: IDLE reads the link and size stores at the
// class head, EXEC updates the head and stores and loads the result register.
// The two-entry queue lets the front accept while the back end works or the result waits.
// Reset is synchronous; free lists come up from store valid bits, no sweep.
// A stalled result holds the back end, which fills the queue and then drops in_ready.
module size_class_buffer_pool (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [scbp_pkg::SIZE_W-1:0] in_req_size,
  input  logic [scbp_pkg::ID_W-1:0]   in_buffer_id,
  input  logic [scbp_pkg::SIZE_W-1:0] in_buffer_size,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [scbp_pkg::ID_W-1:0]   out_granted_id,
  output logic [scbp_pkg::SIZE_W-1:0] out_granted_size,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scbp_pkg::ADDR_W-1:0] paddr,
  input  logic [scbp_pkg::DATA_W-1:0] pwdata,
  output logic [scbp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  scbp_pkg::caps_t            caps_r;
  logic [scbp_pkg::CLS_W-1:0] reg_idx;
  logic                       reg_wr;
  scbp_pkg::op_t              front_op;
  scbp_pkg::op_t              head_op;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[scbp_pkg::ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r[0] <= scbp_pkg::SMALL_CAP_RST;
      caps_r[1] <= scbp_pkg::MEDIUM_CAP_RST;
      caps_r[2] <= scbp_pkg::BIG_CAP_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        scbp_pkg::REG_SMALL_CAP:  caps_r[0] <= pwdata[scbp_pkg::SIZE_W-1:0];
        scbp_pkg::REG_MEDIUM_CAP: caps_r[1] <= pwdata[scbp_pkg::SIZE_W-1:0];
        scbp_pkg::REG_BIG_CAP:    caps_r[2] <= pwdata[scbp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      scbp_pkg::REG_SMALL_CAP:  prdata = scbp_pkg::DATA_W'(caps_r[0]);
      scbp_pkg::REG_MEDIUM_CAP: prdata = scbp_pkg::DATA_W'(caps_r[1]);
      scbp_pkg::REG_BIG_CAP:    prdata = scbp_pkg::DATA_W'(caps_r[2]);
      default:                  prdata = '0;
    endcase
  end

  assign in_ready = !q_full;

  scbp_front u_front (
    .in_action      (in_action),
    .in_req_size    (in_req_size),
    .in_buffer_id   (in_buffer_id),
    .in_buffer_size (in_buffer_size),
    .caps           (caps_r),
    .op             (front_op)
  );

  scbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_op   (head_op)
  );

  scbp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .caps             (caps_r),
    .q_valid          (q_valid),
    .q_op             (head_op),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_id   (out_granted_id),
    .out_granted_size (out_granted_size)
  );

endmodule

@@ sv/scbp_front.sv @@
// Front end: classifies an incoming request against the class capacities.
module scbp_front (
  input  logic                       in_action,
  input  logic [scbp_pkg::SIZE_W-1:0] in_req_size,
  input  logic [scbp_pkg::ID_W-1:0]  in_buffer_id,
  input  logic [scbp_pkg::SIZE_W-1:0] in_buffer_size,
  input  scbp_pkg::caps_t            caps,
  output scbp_pkg::op_t              op
);

  logic [scbp_pkg::SIZE_W-1:0] key;
  logic                        fit;
  logic [scbp_pkg::CLS_W-1:0]  cls;
  logic                        id_ok;

  always_comb begin
    key = (in_action == scbp_pkg::ACT_RELEASE) ? in_buffer_size : in_req_size;
    fit = 1'b0;
    cls = '0;
    for (int c = scbp_pkg::ACTIVE_CLASSES - 1; c >= 0; c--) begin
      if (caps[c] >= key) begin
        fit = 1'b1;
        cls = scbp_pkg::CLS_W'(c);
      end
    end
  end

  assign id_ok = (32'(in_buffer_id) < 32'(scbp_pkg::ID_LIMIT));

  always_comb begin
    op.act  = in_action;
    op.cls  = cls;
    op.size = in_buffer_size;
    if (in_action == scbp_pkg::ACT_RELEASE) begin
      op.ok = fit && id_ok;
      op.id = in_buffer_id;
    end else begin
      op.ok = fit;
      op.id = '0;
    end
  end

endmodule

@@ sv/scbp_queue.sv @@
// Two-entry request queue between the front end and the back end.
module scbp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scbp_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output scbp_pkg::op_t head_op
);

  scbp_pkg::op_t                 mem_r [scbp_pkg::QUEUE_DEPTH];
  logic [scbp_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [scbp_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [scbp_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == scbp_pkg::QCNT_W'(scbp_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_op   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ sv/scbp_back.sv @@
// Back end: free-list heads, link and size stores, pop/push execution and result register.
module scbp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  scbp_pkg::caps_t             caps,
  input  logic                        q_valid,
  input  scbp_pkg::op_t               q_op,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [scbp_pkg::ID_W-1:0]   out_granted_id,
  output logic [scbp_pkg::SIZE_W-1:0] out_granted_size
);

  scbp_pkg::bk_state_t st_r, st_nxt;

  logic [scbp_pkg::ID_W-1:0]   head_r [scbp_pkg::MAX_CLASSES];
  logic [scbp_pkg::ID_W-1:0]   link_mem [scbp_pkg::ID_SLOTS];
  logic [scbp_pkg::SIZE_W-1:0] size_mem [scbp_pkg::ID_SLOTS];
  logic [scbp_pkg::ID_SLOTS-1:0] link_vld_r;
  logic [scbp_pkg::ID_SLOTS-1:0] size_vld_r;

  scbp_pkg::op_t               op_r;
  logic [scbp_pkg::ID_W-1:0]   cur_head_r;
  logic [scbp_pkg::ID_W-1:0]   link_q_r;
  logic [scbp_pkg::SIZE_W-1:0] size_q_r;
  logic                        link_vld_q_r;
  logic                        size_vld_q_r;

  logic                        out_valid_r;
  scbp_pkg::status_t           out_status_r, out_status_nxt;
  logic [scbp_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic [scbp_pkg::SIZE_W-1:0] out_size_r, out_size_nxt;

  logic                        out_free;
  logic                        done;
  logic                        do_pop;
  logic                        do_push;
  logic [scbp_pkg::ID_W-1:0]   pop_next;
  logic [scbp_pkg::ID_W-1:0]   q_head;

  assign out_free = !out_valid_r || out_ready;
  assign q_head   = head_r[q_op.cls];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      scbp_pkg::BK_IDLE: if (q_valid) st_nxt = scbp_pkg::BK_EXEC;
      scbp_pkg::BK_EXEC: if (out_free) st_nxt = scbp_pkg::BK_IDLE;
      default:           st_nxt = scbp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    done  = 1'b0;
    case (st_r)
      scbp_pkg::BK_IDLE: q_pop = q_valid;
      scbp_pkg::BK_EXEC: done  = out_free;
      default: begin
        q_pop = 1'b0;
        done  = 1'b0;
      end
    endcase
  end

  always_comb begin
    do_pop         = 1'b0;
    do_push        = 1'b0;
    pop_next       = link_vld_q_r ? link_q_r : scbp_pkg::link_reset(cur_head_r);
    out_status_nxt = scbp_pkg::STS_NO_FIT;
    out_id_nxt     = op_r.id;
    out_size_nxt   = '0;
    if (!op_r.ok) begin
      out_status_nxt = scbp_pkg::STS_NO_FIT;
    end else if (op_r.act == scbp_pkg::ACT_RELEASE) begin
      out_status_nxt = scbp_pkg::STS_RELEASED;
      do_push        = done;
    end else if (cur_head_r == scbp_pkg::END_MARK) begin
      out_status_nxt = scbp_pkg::STS_EMPTY;
    end else begin
      out_status_nxt = scbp_pkg::STS_GRANTED;
      out_id_nxt     = cur_head_r;
      out_size_nxt   = size_vld_q_r ? size_q_r : caps[op_r.cls];
      do_pop         = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= scbp_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      link_vld_r  <= '0;
      size_vld_r  <= '0;
      for (int c = 0; c < scbp_pkg::MAX_CLASSES; c++) begin
        head_r[c] <= scbp_pkg::class_first(c);
      end
    end else begin
      st_r <= st_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_pop) begin
        head_r[op_r.cls]       <= pop_next;
        link_vld_r[cur_head_r] <= 1'b1;
      end
      if (do_push) begin
        head_r[op_r.cls]    <= op_r.id;
        link_vld_r[op_r.id] <= 1'b1;
        size_vld_r[op_r.id] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r         <= q_op;
      cur_head_r   <= q_head;
      link_q_r     <= link_mem[q_head];
      size_q_r     <= size_mem[q_head];
      link_vld_q_r <= link_vld_r[q_head];
      size_vld_q_r <= size_vld_r[q_head];
    end
    if (do_pop) begin
      link_mem[cur_head_r] <= scbp_pkg::END_MARK;
    end
    if (do_push) begin
      link_mem[op_r.id] <= cur_head_r;
      size_mem[op_r.id] <= op_r.size;
    end
    if (done) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_size_r   <= out_size_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_id   = out_id_r;
  assign out_granted_size = out_size_r;

  a_grant_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == scbp_pkg::STS_GRANTED) |-> out_id_r != scbp_pkg::END_MARK)
    else $error("granted id is the end mark");

  a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != scbp_pkg::STS_GRANTED) |-> out_size_r == '0)
    else $error("nonzero size on a non-grant result");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == scbp_pkg::BK_IDLE)
    else $error("queue popped while executing");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (st_r == scbp_pkg::BK_IDLE && out_valid_r))
    else $error("execute did not retire into the result register");

  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_pop && do_push))
    else $error("pop and push in one cycle");

endmodule

@@ tb/size_class_buffer_pool_test.sv @@
// Self-checking testbench for size_class_buffer_pool: predicted results vs. DUT output.
module size_class_buffer_pool_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scbp_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic              act;
    logic [SIZE_W-1:0] req_size;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] bsize;
  } pool_req_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] grant_size;
  } pool_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_action = ACT_REQUEST;
  logic [SIZE_W-1:0] in_req_size = '0;
  logic [ID_W-1:0]   in_buffer_id = '0;
  logic [SIZE_W-1:0] in_buffer_size = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [ID_W-1:0]   out_granted_id;
  logic [SIZE_W-1:0] out_granted_size;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predicted pool state
  logic [SIZE_W-1:0] cap_q [MAX_CLASSES];
  logic [ID_W-1:0]   head_q [MAX_CLASSES];
  logic [ID_W-1:0]   link_q [ID_SLOTS];
  logic [SIZE_W-1:0] size_q [ID_SLOTS];
  bit                size_set [ID_SLOTS];
  int                id_top;

  // ids the pool has handed out, and ids already queued for release
  bit held [ID_SLOTS];
  bit rel_pend [ID_SLOTS];

  pool_req_t pending[$];
  pool_res_t expected[$];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int quiet = 0;
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int settings_run = 1;
  int status_seen [4] = '{0, 0, 0, 0};

  size_class_buffer_pool DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_req_size      (in_req_size),
    .in_buffer_id     (in_buffer_id),
    .in_buffer_size   (in_buffer_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_id   (out_granted_id),
    .out_granted_size (out_granted_size),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5ns clk = ~clk;

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void pool_reset();
    int id;
    int cnt;
    id = 0;
    cap_q[0] = SMALL_CAP_RST;
    cap_q[1] = MEDIUM_CAP_RST;
    cap_q[2] = BIG_CAP_RST;
    for (int k = 0; k < ID_SLOTS; k++) begin
      link_q[k] = END_MARK;
      size_q[k] = '0;
      size_set[k] = 1'b0;
      held[k] = 1'b0;
      rel_pend[k] = 1'b0;
    end
    for (int c = 0; c < MAX_CLASSES; c++) begin
      head_q[c] = END_MARK;
      cnt = (c == 0) ? SMALL_COUNT : (c == 1) ? MEDIUM_COUNT : BIG_COUNT;
      if (c < ACTIVE_CLASSES) begin
        for (int k = 0; k < cnt && id < ID_SLOTS - 1; k++) begin
          if (k == 0) begin
            head_q[c] = ID_W'(id);
          end else begin
            link_q[id - 1] = ID_W'(id);
          end
          link_q[id] = END_MARK;
          id++;
        end
      end
    end
    id_top = id;
  endfunction

  // one request through the free lists; updates predicted state
  function automatic pool_res_t pool_step(input pool_req_t r);
    pool_res_t o;
    logic [SIZE_W-1:0] need;
    int cls;
    int h;
    need = (r.act == ACT_REQUEST) ? r.req_size : r.bsize;
    cls = -1;
    for (int c = ACTIVE_CLASSES - 1; c >= 0; c--) begin
      if (cap_q[c] >= need) begin
        cls = c;
      end
    end
    o.status = STS_NO_FIT;
    o.id = '0;
    o.grant_size = '0;
    if (r.act == ACT_REQUEST) begin
      if (cls >= 0 && head_q[cls] == END_MARK) begin
        o.status = STS_EMPTY;
      end else if (cls >= 0) begin
        h = head_q[cls];
        head_q[cls] = link_q[h];
        link_q[h] = END_MARK;
        o.id = ID_W'(h);
        o.grant_size = size_set[h] ? size_q[h] : cap_q[cls];
        o.status = STS_GRANTED;
      end
    end else begin
      o.id = r.id;
      if (int'(r.id) < id_top && cls >= 0) begin
        link_q[r.id] = head_q[cls];
        head_q[cls] = r.id;
        size_q[r.id] = r.bsize;
        size_set[r.id] = 1'b1;
        o.status = STS_RELEASED;
      end
    end
    return o;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    v = cap_q[$urandom_range(0, MAX_CLASSES - 1)];
    case (sel)
      0: v = 0;
      1: v = 65535;
      2: v = $urandom_range(0, 65535);
      3: if (v < 65535) v = v + 1;
      default: v = v - $urandom_range(0, (v < 4) ? v : 4);
    endcase
    return SIZE_W'(v);
  endfunction

  task automatic queue_item(input logic act, input int req, input int id, input int bsz);
    pool_req_t r;
    r.act = act;
    r.req_size = SIZE_W'(req);
    r.id = ID_W'(id);
    r.bsize = SIZE_W'(bsz);
    pending.push_back(r);
  endtask

  // mostly well-formed: grants, then releases of ids actually held; some noise
  task automatic queue_random(input int alloc_pct);
    pool_req_t r;
    int owned[$];
    r.act = ACT_REQUEST;
    r.req_size = pick_size();
    r.id = ID_W'($urandom_range(0, ID_SLOTS - 1));
    r.bsize = SIZE_W'($urandom());
    if ($urandom_range(0, 99) < 10) begin
      r.act = ACT_RELEASE;
      r.bsize = pick_size();
    end else if ($urandom_range(0, 99) >= alloc_pct) begin
      for (int i = 0; i < ID_SLOTS; i++) begin
        if (held[i] && !rel_pend[i]) owned.push_back(i);
      end
      if (owned.size() != 0) begin
        r.id = ID_W'(owned[$urandom_range(0, owned.size() - 1)]);
        r.act = ACT_RELEASE;
        r.bsize = pick_size();
        rel_pend[r.id] = 1'b1;
      end
    end
    pending.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending.size() != 0 || in_valid || expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CLS_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_q[idx] = val;
  endtask

  task automatic run_phase(input int items, input int s_pct, input int r_pct,
                           input int c_small, input int c_medium, input int c_big,
                           input bit long_hold, input bit mid_pause);
    wait_drained();
    cfg_write(REG_SMALL_CAP, SIZE_W'(c_small));
    cfg_write(REG_MEDIUM_CAP, SIZE_W'(c_medium));
    cfg_write(REG_BIG_CAP, SIZE_W'(c_big));
    settings_run++;
    @(negedge clk);
    send_idle = s_pct;
    recv_idle = r_pct;
    for (int n = 0; n < items; n++) begin
      while (pending.size() >= 4) @(negedge clk);
      if (long_hold && n == items / 2) hold_req++;
      if (mid_pause && n == items / 2) wait_drained();
      queue_random(((n / 24) % 2) ? 25 : 75);
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive
    pool_req_t got;
    pool_req_t nxt;
    pool_res_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        got.act = in_action;
        got.req_size = in_req_size;
        got.id = in_buffer_id;
        got.bsize = in_buffer_size;
        res = pool_step(got);
        expected.push_back(res);
        status_seen[res.status]++;
        n_in++;
        if (res.status == STS_GRANTED) held[res.id] = 1'b1;
        if (got.act == ACT_RELEASE) begin
          rel_pend[got.id] = 1'b0;
          if (res.status == STS_RELEASED) held[got.id] = 1'b0;
        end
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          in_action <= nxt.act;
          in_req_size <= nxt.req_size;
          in_buffer_id <= nxt.id;
          in_buffer_size <= nxt.bsize;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin : sink
    pool_res_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_out++;
        if (expected.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected: status %0d id %0d size %0d",
                               n_out, out_status, out_granted_id, out_granted_size));
        end else begin
          e = expected.pop_front();
          if (out_status != e.status || out_granted_id != e.id ||
              out_granted_size != e.grant_size) begin
            flag_error($sformatf({"result %0d mismatch: expected status %0d id %0d size %0d,",
                                  " got status %0d id %0d size %0d"},
                                 n_out, e.status, e.id, e.grant_size,
                                 out_status, out_granted_id, out_granted_size));
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, expected.size());
        $display("size_class_buffer_pool_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int lo;
    int mid;
    pool_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset capacities 32/64/128
    queue_item(ACT_REQUEST, 0, 0, 0);
    queue_item(ACT_REQUEST, 32, 63, 65535);
    queue_item(ACT_REQUEST, 33, 0, 0);
    queue_item(ACT_REQUEST, 128, 0, 0);
    queue_item(ACT_REQUEST, 129, 0, 0);
    queue_item(ACT_REQUEST, 65535, 0, 0);
    queue_item(ACT_RELEASE, 0, 0, 0);
    queue_item(ACT_REQUEST, 1, 0, 0);
    queue_item(ACT_RELEASE, 0, 47, 128);
    queue_item(ACT_RELEASE, 0, 48, 10);
    queue_item(ACT_RELEASE, 65535, 63, 65535);
    queue_item(ACT_RELEASE, 0, 5, 200);
    queue_item(ACT_RELEASE, 0, 20, 64);
    queue_item(ACT_RELEASE, 0, 33, 1);
    queue_item(ACT_REQUEST, 2, 0, 0);
    queue_item(ACT_REQUEST, 100, 0, 0);

    run_phase(128, 0, 0, 32, 64, 128, 1'b1, 1'b0);
    run_phase(128, 46, 0, 0, 0, 0, 1'b0, 1'b0);
    run_phase(128, 0, 46, 65535, 65535, 65535, 1'b0, 1'b0);
    lo = $urandom_range(0, 200);
    mid = lo + $urandom_range(0, 300);
    run_phase(128, 14, 14, lo, mid, mid + $urandom_range(0, 1000), 1'b0, 1'b0);
    run_phase(128, 0, 0, 200, 100, 65535, 1'b0, 1'b1);
    run_phase(128, 46, 0, 1, 65535, 2, 1'b0, 1'b0);
    run_phase(128, 0, 46, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), 1'b0, 1'b0);
    run_phase(128, 14, 14, 32, 64, 128, 1'b0, 1'b0);

    wait_drained();
    repeat (10) @(negedge clk);
    if (expected.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", expected.size()));
    end
    $display("covered %0d requests over %0d capacity settings, %0d results checked",
             n_in, settings_run, n_out);
    $display("grants %0d, releases %0d, no-fit %0d, empty class %0d, mismatches %0d",
             status_seen[STS_GRANTED], status_seen[STS_RELEASED],
             status_seen[STS_NO_FIT], status_seen[STS_EMPTY], errors);
    if (errors == 0) begin
      $display("size_class_buffer_pool_test: clean");
    end else begin
      $display("size_class_buffer_pool_test: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/scbp_pkg.sv
sv/scbp_front.sv
sv/scbp_queue.sv
sv/scbp_back.sv
sv/size_class_buffer_pool.sv
tb/size_class_buffer_pool_test.sv
